[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/rvlg_pkg.sv]
// Package with the shared types and constants of the scanline video generator.
`timescale 1ns / 1ps
`default_nettype none
package rvlg_pkg;

    localparam int CHAR_ROM_DEPTH_DEF = 512;
    localparam int BYTES_PER_LINE     = 40;
    localparam int FRAME_LINES        = 262;
    localparam int VISIBLE_LINES      = 192;
    localparam int MIXED_START        = 160;
    localparam logic [7:0]  RESET_INTERVAL = 8'd22;
    localparam logic [15:0] TEXT_PAGE_ONE  = 16'h0400;
    localparam logic [15:0] TEXT_PAGE_TWO  = 16'h0800;
    localparam logic [15:0] HIRES_PAGE_ONE = 16'h2000;
    localparam logic [15:0] HIRES_PAGE_TWO = 16'h4000;

    typedef enum logic [1:0] {
        KIND_SWITCH  = 2'd0,
        KIND_ROM_WR  = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_DISPLAY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SW_TEXT  = 2'd0,
        SW_MIXED = 2'd1,
        SW_PAGE  = 2'd2,
        SW_HIRES = 2'd3
    } sw_sel_t;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_LORES = 2'd1,
        MODE_HIRES = 2'd2,
        MODE_BLANK = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        sw_sel_t     sw_sel;
        logic        sw_val;
        logic [8:0]  rom_address;
        logic [7:0]  data_byte;
        logic        odd;
    } entry_t;

    typedef struct packed {
        logic [6:0][2:0] pixels;
        logic [15:0]     row_address;
        mode_t           line_mode;
        logic            frame_done;
    } result_t;

endpackage
`default_nettype wire

[rtl/rvlg_front.sv]
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module rvlg_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_req_type,
    input  wire logic [2:0]      s_switch_index,
    input  wire logic [8:0]      s_rom_address,
    input  wire logic [7:0]      s_data_byte,
    input  wire logic [5:0]      s_column,
    output rvlg_pkg::entry_t     head,
    output logic                 head_valid,
    input  wire logic            pop
);
    import rvlg_pkg::*;

    entry_t      fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    entry_t      entry;
    logic        push;

    always_comb begin
        entry.kind        = kind_t'(s_req_type);
        entry.sw_sel      = sw_sel_t'(s_switch_index[2:1]);
        entry.sw_val      = s_switch_index[0];
        entry.rom_address = s_rom_address;
        entry.data_byte   = s_data_byte;
        entry.odd         = s_column[0];
    end

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

[rtl/rvlg_back.sv]
// Back end: display state, glyph memory and the pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none
module rvlg_back #(
    parameter int CHAR_ROM_DEPTH = rvlg_pkg::CHAR_ROM_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rvlg_pkg::entry_t head,
    input  wire logic            head_valid,
    output logic                 pop,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output rvlg_pkg::result_t    result
);
    import rvlg_pkg::*;

    localparam int AW = $clog2(CHAR_ROM_DEPTH);

    logic [7:0]  char_rom [CHAR_ROM_DEPTH];
    logic [7:0]  rom_q_reg;

    logic [8:0]  line_cnt_reg, line_cnt_next;
    logic        text_reg, text_next;
    logic        mixed_reg, mixed_next;
    logic        page_one_reg, page_one_next;
    logic        hires_reg, hires_next;
    logic        blink_reg, blink_next;
    logic [7:0]  blink_cd_reg, blink_cd_next;
    logic [7:0]  blink_int_reg;
    logic [7:0]  lat_line_reg, lat_line_next;
    mode_t       lat_mode_reg, lat_mode_next;
    logic        prev_lit_reg, prev_lit_next;

    logic            b_valid_reg, b_valid_next;
    logic            b_text_reg, b_text_next;
    logic            b_inv_reg, b_inv_next;
    logic [6:0][2:0] b_px_reg, b_px_next;
    logic [15:0]     b_row_reg, b_row_next;
    mode_t           b_mode_reg, b_mode_next;
    logic            b_frame_reg, b_frame_next;

    logic            adv;
    mode_t           vis_mode;
    logic [4:0]      row_grp;
    logic [15:0]     row_off;
    logic [7:0]      cd_dec;
    logic [3:0]      nib;
    logic [6:0][2:0] px;
    logic [6:0]      lit;
    logic [6:0][2:0] gfx;
    logic [8:0]      glyph_idx;
    logic [1:0]      k;
    logic            pos_hi;
    logic            bit_v;

    assign cfg_ready = 1'b1;
    assign adv       = !b_valid_reg || m_ready;
    assign pop       = head_valid && adv;
    assign glyph_idx = {head.data_byte[5:0], lat_line_reg[2:0]};

    always_comb begin
        vis_mode = MODE_LORES;
        if (text_reg || (line_cnt_reg >= 9'(MIXED_START) && mixed_reg)) begin
            vis_mode = MODE_TEXT;
        end else if (hires_reg) begin
            vis_mode = MODE_HIRES;
        end
        row_grp = line_cnt_reg[7:3];
        row_off = {6'd0, row_grp[2:0], 7'd0} + 16'(row_grp[4:3]) * 16'(BYTES_PER_LINE);
        cd_dec  = blink_cd_reg - 8'd1;
        nib     = lat_line_reg[2] ? head.data_byte[7:4] : head.data_byte[3:0];
        k       = 2'd0;

        for (int i = 0; i < 7; i++) begin
            if (lat_mode_reg == MODE_HIRES) begin
                pos_hi = ((i % 2) == 0) ^ head.odd;
                bit_v  = head.data_byte[i];
                px[i]  = {head.data_byte[7], pos_hi & bit_v, !pos_hi & bit_v};
            end else begin
                k      = head.odd ? 2'((i + 3) % 4) : 2'(i % 4);
                bit_v  = nib[k];
                pos_hi = !k[0];
                px[i]  = {1'b0, pos_hi & bit_v, !pos_hi & bit_v};
            end
            lit[i] = bit_v;
        end
        for (int i = 0; i < 7; i++) begin
            if (lit[i] && ((i == 0) ? prev_lit_reg : lit[(i == 0) ? 0 : i - 1])) begin
                gfx[i] = 3'd7;
            end else begin
                gfx[i] = px[i];
            end
        end

        line_cnt_next = line_cnt_reg;
        text_next     = text_reg;
        mixed_next    = mixed_reg;
        page_one_next = page_one_reg;
        hires_next    = hires_reg;
        blink_next    = blink_reg;
        blink_cd_next = blink_cd_reg;
        lat_line_next = lat_line_reg;
        lat_mode_next = lat_mode_reg;
        prev_lit_next = prev_lit_reg;

        b_text_next  = 1'b0;
        b_inv_next   = !head.data_byte[7] && (!head.data_byte[6] || blink_reg);
        b_px_next    = '0;
        b_row_next   = 16'd0;
        b_frame_next = 1'b0;

        case (head.kind)
            KIND_SWITCH: begin
                case (head.sw_sel)
                    SW_TEXT:  text_next     = head.sw_val;
                    SW_MIXED: mixed_next    = head.sw_val;
                    SW_PAGE:  page_one_next = !head.sw_val;
                    SW_HIRES: hires_next    = head.sw_val;
                    default:  hires_next    = hires_reg;
                endcase
            end
            KIND_TICK: begin
                prev_lit_next = 1'b0;
                if (line_cnt_reg < 9'(VISIBLE_LINES)) begin
                    if (vis_mode == MODE_HIRES) begin
                        b_row_next = (page_one_reg ? HIRES_PAGE_ONE : HIRES_PAGE_TWO) + row_off
                                   + {3'd0, line_cnt_reg[2:0], 10'd0};
                    end else begin
                        b_row_next = (page_one_reg ? TEXT_PAGE_ONE : TEXT_PAGE_TWO) + row_off;
                    end
                    lat_line_next = line_cnt_reg[7:0];
                    lat_mode_next = vis_mode;
                    line_cnt_next = line_cnt_reg + 9'd1;
                end else if (line_cnt_reg >= 9'(FRAME_LINES)) begin
                    lat_line_next = 8'd0;
                    lat_mode_next = MODE_BLANK;
                    line_cnt_next = 9'd0;
                    b_frame_next  = 1'b1;
                    blink_cd_next = cd_dec;
                    if (cd_dec == 8'd0) begin
                        blink_cd_next = blink_int_reg;
                        blink_next    = !blink_reg;
                    end
                end else begin
                    lat_line_next = 8'd0;
                    lat_mode_next = MODE_BLANK;
                    line_cnt_next = line_cnt_reg + 9'd1;
                end
            end
            KIND_DISPLAY: begin
                if (lat_mode_reg == MODE_TEXT) begin
                    b_text_next = 1'b1;
                end else if (lat_mode_reg != MODE_BLANK) begin
                    b_px_next     = gfx;
                    prev_lit_next = lit[6];
                end
            end
            default: begin
                b_text_next = 1'b0;
            end
        endcase
        b_mode_next  = lat_mode_next;
        b_valid_next = adv ? head_valid : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_cnt_reg  <= 9'd0;
            text_reg      <= 1'b0;
            mixed_reg     <= 1'b0;
            page_one_reg  <= 1'b0;
            hires_reg     <= 1'b0;
            blink_reg     <= 1'b0;
            blink_cd_reg  <= RESET_INTERVAL;
            blink_int_reg <= RESET_INTERVAL;
            lat_line_reg  <= 8'd0;
            lat_mode_reg  <= MODE_BLANK;
            prev_lit_reg  <= 1'b0;
            b_valid_reg   <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            if (cfg_valid) begin
                blink_int_reg <= cfg_data;
            end
            if (pop) begin
                line_cnt_reg <= line_cnt_next;
                text_reg     <= text_next;
                mixed_reg    <= mixed_next;
                page_one_reg <= page_one_next;
                hires_reg    <= hires_next;
                blink_reg    <= blink_next;
                blink_cd_reg <= blink_cd_next;
                lat_line_reg <= lat_line_next;
                lat_mode_reg <= lat_mode_next;
                prev_lit_reg <= prev_lit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b_text_reg  <= b_text_next;
            b_inv_reg   <= b_inv_next;
            b_px_reg    <= b_px_next;
            b_row_reg   <= b_row_next;
            b_mode_reg  <= b_mode_next;
            b_frame_reg <= b_frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.kind == KIND_ROM_WR) begin
            char_rom[AW'(head.rom_address)] <= head.data_byte;
        end
        if (pop && head.kind == KIND_DISPLAY) begin
            rom_q_reg <= char_rom[AW'(glyph_idx)];
        end
    end

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            if (b_text_reg) begin
                result.pixels[i] = (rom_q_reg[i + 1] ^ b_inv_reg) ? 3'd7 : 3'd0;
            end else begin
                result.pixels[i] = b_px_reg[i];
            end
        end
        result.row_address = b_row_reg;
        result.line_mode   = b_mode_reg;
        result.frame_done  = b_frame_reg;
    end

    assign m_valid = b_valid_reg;

endmodule
`default_nettype wire

[rtl/retro_video_line_generator_top.sv]
// Top level of the scanline video generator.
//
//  Channel   Direction  Handshake            Word
//  s_        in         s_valid / s_ready    req_type, switch_index, rom_address, data_byte, column
//  m_        out        m_valid / m_ready    pixel_0..pixel_6, row_address, line_mode, frame_done
//  cfg_      in         cfg_valid / cfg_ready  blink interval
//
// One word is accepted per cycle while the result port is not stalled, and every word gives one result word.
// A word is written into the two-entry queue and from its head loads the execute stage, where the
// glyph memory read is registered; its result is driven onto the port from the execute stage registers.
// Reset is synchronous and clears the queue, the pipeline and the display state.
// A stalled result holds the execute stage; the queue keeps taking words until full.
`timescale 1ns / 1ps
`default_nettype none
module retro_video_line_generator_top #(
    parameter int CHAR_ROM_DEPTH = rvlg_pkg::CHAR_ROM_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [2:0]  s_switch_index,
    input  wire logic [8:0]  s_rom_address,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [5:0]  s_column,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_pixel_0,
    output logic [2:0]       m_pixel_1,
    output logic [2:0]       m_pixel_2,
    output logic [2:0]       m_pixel_3,
    output logic [2:0]       m_pixel_4,
    output logic [2:0]       m_pixel_5,
    output logic [2:0]       m_pixel_6,
    output logic [15:0]      m_row_address,
    output logic [1:0]       m_line_mode,
    output logic             m_frame_done
);
    import rvlg_pkg::*;

    entry_t  head;
    logic    head_valid;
    logic    pop;
    result_t result;

    rvlg_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_switch_index (s_switch_index),
        .s_rom_address  (s_rom_address),
        .s_data_byte    (s_data_byte),
        .s_column       (s_column),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    rvlg_back #(
        .CHAR_ROM_DEPTH (CHAR_ROM_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_pixel_0     = result.pixels[0];
    assign m_pixel_1     = result.pixels[1];
    assign m_pixel_2     = result.pixels[2];
    assign m_pixel_3     = result.pixels[3];
    assign m_pixel_4     = result.pixels[4];
    assign m_pixel_5     = result.pixels[5];
    assign m_pixel_6     = result.pixels[6];
    assign m_row_address = result.row_address;
    assign m_line_mode   = result.line_mode;
    assign m_frame_done  = result.frame_done;

endmodule
`default_nettype wire

[rtl/rvlg_checker.sv]
// Port checker for the scanline video generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rvlg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_pixel_0,
    input wire logic [2:0]  m_pixel_6,
    input wire logic [15:0] m_row_address,
    input wire logic [1:0]  m_line_mode,
    input wire logic        m_frame_done
);
    import rvlg_pkg::*;

    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_row_address) && $stable(m_line_mode) && $stable(m_pixel_0) && $stable(m_pixel_6))
    `ASSERT_SAME(a_frame_end, aclk, aresetn, m_valid && m_frame_done, m_row_address == 16'd0 && m_line_mode == MODE_BLANK)
    `ASSERT_SAME(a_blank_dark, aclk, aresetn, m_valid && m_line_mode == MODE_BLANK, m_pixel_0 == 3'd0 && m_pixel_6 == 3'd0 && m_row_address == 16'd0)
    `ASSERT_SAME(a_row_tick, aclk, aresetn, m_valid && m_row_address != 16'd0, m_line_mode != MODE_BLANK && !m_frame_done && m_pixel_0 == 3'd0)

endmodule

bind retro_video_line_generator_top rvlg_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_0     (m_pixel_0),
    .m_pixel_6     (m_pixel_6),
    .m_row_address (m_row_address),
    .m_line_mode   (m_line_mode),
    .m_frame_done  (m_frame_done)
);
`default_nettype wire
